>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sample class counter block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert with reset gating
`define MSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assert with no reset gating
`define MSC_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Types, counter indexes and status codes for the sample class counters.
// ----------------------------------------------------------------------------
package msc_pkg;

   localparam int CounterWidthDefault = 32;
   localparam int NumCounters         = 32;
   localparam int CntIdxWidth         = 5;
   localparam int QueueDepth          = 2;

   localparam logic KindSample = 1'b0;
   localparam logic KindRead   = 1'b1;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusNoAddr  = 2'd1;
   localparam logic [1:0] StatusNoParse = 2'd2;
   localparam logic [1:0] StatusNoMap   = 2'd3;

   localparam int CntNrEntries = 0;
   localparam int CntLocks     = 1;
   localparam int CntStore     = 2;
   localparam int CntStUncache = 3;
   localparam int CntStNoAdrs  = 4;
   localparam int CntStL1Hit   = 5;
   localparam int CntStL1Miss  = 6;
   localparam int CntStNa      = 7;
   localparam int CntLoad      = 8;
   localparam int CntLdExcl    = 9;
   localparam int CntLdShared  = 10;
   localparam int CntLdUncache = 11;
   localparam int CntLdIo      = 12;
   localparam int CntLdMiss    = 13;
   localparam int CntLdNoAdrs  = 14;
   localparam int CntLdFbHit   = 15;
   localparam int CntLdL1Hit   = 16;
   localparam int CntLdL2Hit   = 17;
   localparam int CntLdLlcHit  = 18;
   localparam int CntLclHitm   = 19;
   localparam int CntRmtHitm   = 20;
   localparam int CntTotHitm   = 21;
   localparam int CntLclPeer   = 22;
   localparam int CntRmtPeer   = 23;
   localparam int CntTotPeer   = 24;
   localparam int CntRmtHit    = 25;
   localparam int CntLclDram   = 26;
   localparam int CntRmtDram   = 27;
   localparam int CntBlkData   = 28;
   localparam int CntBlkAddr   = 29;
   localparam int CntNoMap     = 30;
   localparam int CntNoParse   = 31;

   typedef struct packed {
      logic        kind;
      logic [4:0]  op_flags;
      logic [13:0] level_flags;
      logic [4:0]  snoop_flags;
      logic [1:0]  snoopx_flags;
      logic [1:0]  lock_flags;
      logic [2:0]  block_flags;
      logic        remote_flag;
      logic [2:0]  hop_count;
      logic        has_data_address;
      logic [1:0]  map_flags;
      logic [4:0]  counter_select;
   } msc_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] counter_value;
   } msc_rsp_type;

   // classified request: per-counter increment (0..3), status and read select
   typedef struct packed {
      logic                              kind;
      logic [CntIdxWidth-1:0]            counter_select;
      logic [1:0]                        status;
      logic [NumCounters-1:0][1:0]       inc;
   } msc_entry_type;

endpackage

>>> sv/msc_front.sv
// ----------------------------------------------------------------------------
// msc_front
// Accepts requests and decodes the sample flags into counter increments.
// ----------------------------------------------------------------------------
module msc_front (
   input  logic                  req_valid,
   input  msc_pkg::msc_req_type  req_data,
   input  logic                  full,
   output logic                  push,
   output msc_pkg::msc_entry_type entry
);

   localparam int LvNa     = 0;
   localparam int LvHit    = 1;
   localparam int LvMiss   = 2;
   localparam int LvL1     = 3;
   localparam int LvLfb    = 4;
   localparam int LvL2     = 5;
   localparam int LvL3     = 6;
   localparam int LvLocRam = 7;
   localparam int LvRemRam1 = 8;
   localparam int LvRemRam2 = 9;
   localparam int LvRemCce1 = 10;
   localparam int LvRemCce2 = 11;
   localparam int LvIo     = 12;
   localparam int LvUnc    = 13;

   logic [13:0]                      lvl;
   logic                             mrem;
   logic                             s_hit;
   logic                             s_hitm;
   logic                             x_peer;
   logic [msc_pkg::NumCounters-1:0][1:0] inc;
   logic [1:0]                       status;

   assign push = req_valid & ~full;
   assign lvl  = req_data.level_flags;
   assign mrem = req_data.remote_flag & (req_data.hop_count == 3'd0);
   assign s_hit  = req_data.snoop_flags[2];
   assign s_hitm = req_data.snoop_flags[4];
   assign x_peer = req_data.snoopx_flags[1];

   always_comb begin
      inc    = '0;
      status = msc_pkg::StatusOk;
      if (req_data.kind == msc_pkg::KindSample) begin
         inc[msc_pkg::CntNrEntries] = inc[msc_pkg::CntNrEntries] + 2'd1;
         if (req_data.lock_flags[1]) inc[msc_pkg::CntLocks] = inc[msc_pkg::CntLocks] + 2'd1;
         if (req_data.block_flags[1]) inc[msc_pkg::CntBlkData] = inc[msc_pkg::CntBlkData] + 2'd1;
         if (req_data.block_flags[2]) inc[msc_pkg::CntBlkAddr] = inc[msc_pkg::CntBlkAddr] + 2'd1;
         if (req_data.op_flags[1]) begin
            inc[msc_pkg::CntLoad] = inc[msc_pkg::CntLoad] + 2'd1;
            if (!req_data.has_data_address) begin
               inc[msc_pkg::CntLdNoAdrs] = inc[msc_pkg::CntLdNoAdrs] + 2'd1;
               status = msc_pkg::StatusNoAddr;
            end else begin
               if (lvl[LvHit]) begin
                  if (lvl[LvUnc]) inc[msc_pkg::CntLdUncache] = inc[msc_pkg::CntLdUncache] + 2'd1;
                  if (lvl[LvIo]) inc[msc_pkg::CntLdIo] = inc[msc_pkg::CntLdIo] + 2'd1;
                  if (lvl[LvLfb]) inc[msc_pkg::CntLdFbHit] = inc[msc_pkg::CntLdFbHit] + 2'd1;
                  if (lvl[LvL1]) inc[msc_pkg::CntLdL1Hit] = inc[msc_pkg::CntLdL1Hit] + 2'd1;
                  if (lvl[LvL2]) begin
                     if (s_hitm) begin
                        inc[msc_pkg::CntLclHitm] = inc[msc_pkg::CntLclHitm] + 2'd1;
                        inc[msc_pkg::CntTotHitm] = inc[msc_pkg::CntTotHitm] + 2'd1;
                     end else begin
                        inc[msc_pkg::CntLdL2Hit] = inc[msc_pkg::CntLdL2Hit] + 2'd1;
                     end
                     if (x_peer) begin
                        inc[msc_pkg::CntLclPeer] = inc[msc_pkg::CntLclPeer] + 2'd1;
                        inc[msc_pkg::CntTotPeer] = inc[msc_pkg::CntTotPeer] + 2'd1;
                     end
                  end
                  if (lvl[LvL3]) begin
                     if (s_hitm) begin
                        inc[msc_pkg::CntLclHitm] = inc[msc_pkg::CntLclHitm] + 2'd1;
                        inc[msc_pkg::CntTotHitm] = inc[msc_pkg::CntTotHitm] + 2'd1;
                     end else begin
                        inc[msc_pkg::CntLdLlcHit] = inc[msc_pkg::CntLdLlcHit] + 2'd1;
                     end
                     if (x_peer) begin
                        inc[msc_pkg::CntLclPeer] = inc[msc_pkg::CntLclPeer] + 2'd1;
                        inc[msc_pkg::CntTotPeer] = inc[msc_pkg::CntTotPeer] + 2'd1;
                     end
                  end
                  if (lvl[LvLocRam]) begin
                     inc[msc_pkg::CntLclDram] = inc[msc_pkg::CntLclDram] + 2'd1;
                     if (s_hit) inc[msc_pkg::CntLdShared] = inc[msc_pkg::CntLdShared] + 2'd1;
                     else inc[msc_pkg::CntLdExcl] = inc[msc_pkg::CntLdExcl] + 2'd1;
                  end
                  if (lvl[LvRemRam1] || lvl[LvRemRam2] || mrem) begin
                     inc[msc_pkg::CntRmtDram] = inc[msc_pkg::CntRmtDram] + 2'd1;
                     if (s_hit) inc[msc_pkg::CntLdShared] = inc[msc_pkg::CntLdShared] + 2'd1;
                     else inc[msc_pkg::CntLdExcl] = inc[msc_pkg::CntLdExcl] + 2'd1;
                  end
               end
               if (lvl[LvRemCce1] || lvl[LvRemCce2] || mrem) begin
                  if (s_hit) begin
                     inc[msc_pkg::CntRmtHit] = inc[msc_pkg::CntRmtHit] + 2'd1;
                  end else if (s_hitm) begin
                     inc[msc_pkg::CntRmtHitm] = inc[msc_pkg::CntRmtHitm] + 2'd1;
                     inc[msc_pkg::CntTotHitm] = inc[msc_pkg::CntTotHitm] + 2'd1;
                  end else if (x_peer) begin
                     inc[msc_pkg::CntRmtHit] = inc[msc_pkg::CntRmtHit] + 2'd1;
                     inc[msc_pkg::CntRmtPeer] = inc[msc_pkg::CntRmtPeer] + 2'd1;
                     inc[msc_pkg::CntTotPeer] = inc[msc_pkg::CntTotPeer] + 2'd1;
                  end
               end
               if (lvl[LvMiss]) inc[msc_pkg::CntLdMiss] = inc[msc_pkg::CntLdMiss] + 2'd1;
               if (req_data.map_flags != 2'b11) begin
                  inc[msc_pkg::CntNoMap] = inc[msc_pkg::CntNoMap] + 2'd1;
                  status = msc_pkg::StatusNoMap;
               end
            end
         end else if (req_data.op_flags[2]) begin
            inc[msc_pkg::CntStore] = inc[msc_pkg::CntStore] + 2'd1;
            if (!req_data.has_data_address) begin
               inc[msc_pkg::CntStNoAdrs] = inc[msc_pkg::CntStNoAdrs] + 2'd1;
               status = msc_pkg::StatusNoAddr;
            end else begin
               if (lvl[LvHit]) begin
                  if (lvl[LvUnc]) inc[msc_pkg::CntStUncache] = inc[msc_pkg::CntStUncache] + 2'd1;
                  if (lvl[LvL1]) inc[msc_pkg::CntStL1Hit] = inc[msc_pkg::CntStL1Hit] + 2'd1;
               end
               if (lvl[LvMiss] && lvl[LvL1]) begin
                  inc[msc_pkg::CntStL1Miss] = inc[msc_pkg::CntStL1Miss] + 2'd1;
               end
               if (lvl[LvNa]) inc[msc_pkg::CntStNa] = inc[msc_pkg::CntStNa] + 2'd1;
               if (req_data.map_flags != 2'b11) begin
                  inc[msc_pkg::CntNoMap] = inc[msc_pkg::CntNoMap] + 2'd1;
                  status = msc_pkg::StatusNoMap;
               end
            end
         end else begin
            inc[msc_pkg::CntNoParse] = inc[msc_pkg::CntNoParse] + 2'd1;
            status = msc_pkg::StatusNoParse;
         end
      end
   end

   always_comb begin
      entry.kind           = req_data.kind;
      entry.counter_select = req_data.counter_select;
      entry.status         = status;
      entry.inc            = inc;
   end

endmodule

>>> sv/msc_queue.sv
// ----------------------------------------------------------------------------
// msc_queue
// Short FIFO of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module msc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  msc_pkg::msc_entry_type push_entry,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output msc_pkg::msc_entry_type head
);

   localparam int PtrW = $clog2(msc_pkg::QueueDepth);
   localparam int CntW = $clog2(msc_pkg::QueueDepth + 1);

   msc_pkg::msc_entry_type mem_ff [msc_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(msc_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(msc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(msc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/msc_back.sv
// ----------------------------------------------------------------------------
// msc_back
// Applies counter increments and produces the response register.
// ----------------------------------------------------------------------------
module msc_back #(
   parameter int COUNTER_WIDTH = msc_pkg::CounterWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   not_empty,
   input  msc_pkg::msc_entry_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output msc_pkg::msc_rsp_type   rsp_data
);

   localparam int ExtW = COUNTER_WIDTH + 32;

   logic [COUNTER_WIDTH-1:0] cnt_ff [msc_pkg::NumCounters];
   logic                     rsp_valid_ff, rsp_valid_in;
   msc_pkg::msc_rsp_type     rsp_ff, rsp_in;
   logic [ExtW-1:0]          sel_ext;

   assign pop          = not_empty & (~rsp_valid_ff | ~rsp_stall);
   assign sel_ext      = ExtW'(cnt_ff[head.counter_select]);
   assign rsp_valid_in = pop | (rsp_valid_ff & rsp_stall);

   always_comb begin
      rsp_in = rsp_ff;
      if (pop) begin
         if (head.kind == msc_pkg::KindRead) begin
            rsp_in.status        = msc_pkg::StatusOk;
            rsp_in.counter_value = sel_ext[31:0];
         end else begin
            rsp_in.status        = head.status;
            rsp_in.counter_value = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < msc_pkg::NumCounters; i++) cnt_ff[i] <= '0;
      end else if (pop) begin
         for (int i = 0; i < msc_pkg::NumCounters; i++) begin
            cnt_ff[i] <= cnt_ff[i] + COUNTER_WIDTH'(head.inc[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/mem_sample_class_counters.sv
// ----------------------------------------------------------------------------
// mem_sample_class_counters
// Memory-access sample classifier feeding a bank of 32 wrapping counters.
// ----------------------------------------------------------------------------
// Takes one request per clock. A sample request is decoded in the front part
// into per-counter increments and queued; the back part adds them to the
// counter bank and returns the status. A read request returns the low 32 bits
// of one counter and sees every earlier sample. An accepted request passes
// through the queue entry and then the response register. Requests stall
// only when the two-entry queue fills behind a stalled response.
module mem_sample_class_counters #(
   parameter int COUNTER_WIDTH = msc_pkg::CounterWidthDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  msc_pkg::msc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output msc_pkg::msc_rsp_type rsp_data
);

   logic                   push;
   logic                   pop;
   logic                   full;
   logic                   not_empty;
   msc_pkg::msc_entry_type push_entry;
   msc_pkg::msc_entry_type head;

   assign req_stall = full;

   msc_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .full      (full),
      .push      (push),
      .entry     (push_entry)
   );

   msc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   msc_back #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> sv/msc_checker.sv
// ----------------------------------------------------------------------------
// msc_checker
// Port-level assertions for the sample class counter block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input msc_pkg::msc_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input msc_pkg::msc_rsp_type rsp_data
);

   `MSC_ASSERT(a_req_hold, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_data), "request changed while stalled")
   `MSC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "response changed while stalled")
   `MSC_ASSERT_NR(a_reset_clears, clock, reset |=> !rsp_valid, "response valid after reset")
   `MSC_ASSERT(a_stall_backlog, clock, reset, req_stall |-> rsp_valid, "request stalled with no pending response")
   `MSC_ASSERT(a_err_zero, clock, reset, rsp_valid && rsp_data.status != msc_pkg::StatusOk |-> rsp_data.counter_value == 32'd0, "error response carries counter data")

endmodule

bind mem_sample_class_counters msc_checker u_msc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> verif/msc_class_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_class_checker
// Watches both channels of the sample class counter block. Every accepted
// sample is classified into a private copy of the counter bank, a read
// looks its counter up there, and the predicted response is queued. Every
// accepted response is compared field by field with the oldest prediction.
// Failures and pending predictions are reported to the testbench top.
// ----------------------------------------------------------------------------
module msc_class_checker
   import msc_pkg::*;
#(
   parameter int COUNTER_WIDTH = CounterWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  msc_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  msc_rsp_type rsp_data,
   output int          fail_count,
   output int          pending_count
);

   localparam int LvNa     = 0;
   localparam int LvHit    = 1;
   localparam int LvMiss   = 2;
   localparam int LvL1     = 3;
   localparam int LvLfb    = 4;
   localparam int LvL2     = 5;
   localparam int LvL3     = 6;
   localparam int LvLocRam = 7;
   localparam int LvRemRam1 = 8;
   localparam int LvRemRam2 = 9;
   localparam int LvRemCce1 = 10;
   localparam int LvRemCce2 = 11;
   localparam int LvIo     = 12;
   localparam int LvUnc    = 13;

   logic [COUNTER_WIDTH-1:0] class_count [NumCounters];
   msc_rsp_type              expected_rsp_q [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic void bump_count(input int idx);
      class_count[idx] = class_count[idx] + 1'b1;
   endfunction

   function automatic void count_dram_share(input logic snoop_hit);
      if (snoop_hit) begin
         bump_count(CntLdShared);
      end else begin
         bump_count(CntLdExcl);
      end
   endfunction

   function automatic logic [1:0] classify_sample(input msc_req_type r);
      logic [13:0] lv;
      logic        s_hit;
      logic        s_hitm;
      logic        x_peer;
      logic        rem_no_hops;
      lv          = r.level_flags;
      s_hit       = r.snoop_flags[2];
      s_hitm      = r.snoop_flags[4];
      x_peer      = r.snoopx_flags[1];
      rem_no_hops = r.remote_flag && (r.hop_count == 3'd0);

      bump_count(CntNrEntries);
      if (r.lock_flags[1]) bump_count(CntLocks);
      if (r.block_flags[1]) bump_count(CntBlkData);
      if (r.block_flags[2]) bump_count(CntBlkAddr);

      if (r.op_flags[1]) begin
         bump_count(CntLoad);
         if (!r.has_data_address) begin
            bump_count(CntLdNoAdrs);
            return StatusNoAddr;
         end
         if (lv[LvHit]) begin
            if (lv[LvUnc]) bump_count(CntLdUncache);
            if (lv[LvIo]) bump_count(CntLdIo);
            if (lv[LvLfb]) bump_count(CntLdFbHit);
            if (lv[LvL1]) bump_count(CntLdL1Hit);
            if (lv[LvL2]) begin
               if (s_hitm) begin
                  bump_count(CntLclHitm);
                  bump_count(CntTotHitm);
               end else begin
                  bump_count(CntLdL2Hit);
               end
               if (x_peer) begin
                  bump_count(CntLclPeer);
                  bump_count(CntTotPeer);
               end
            end
            if (lv[LvL3]) begin
               if (s_hitm) begin
                  bump_count(CntLclHitm);
                  bump_count(CntTotHitm);
               end else begin
                  bump_count(CntLdLlcHit);
               end
               if (x_peer) begin
                  bump_count(CntLclPeer);
                  bump_count(CntTotPeer);
               end
            end
            if (lv[LvLocRam]) begin
               bump_count(CntLclDram);
               count_dram_share(s_hit);
            end
            if (lv[LvRemRam1] || lv[LvRemRam2] || rem_no_hops) begin
               bump_count(CntRmtDram);
               count_dram_share(s_hit);
            end
         end
         if (lv[LvRemCce1] || lv[LvRemCce2] || rem_no_hops) begin
            if (s_hit) begin
               bump_count(CntRmtHit);
            end else if (s_hitm) begin
               bump_count(CntRmtHitm);
               bump_count(CntTotHitm);
            end else if (x_peer) begin
               bump_count(CntRmtHit);
               bump_count(CntRmtPeer);
               bump_count(CntTotPeer);
            end
         end
         if (lv[LvMiss]) bump_count(CntLdMiss);
      end else if (r.op_flags[2]) begin
         bump_count(CntStore);
         if (!r.has_data_address) begin
            bump_count(CntStNoAdrs);
            return StatusNoAddr;
         end
         if (lv[LvHit]) begin
            if (lv[LvUnc]) bump_count(CntStUncache);
            if (lv[LvL1]) bump_count(CntStL1Hit);
         end
         if (lv[LvMiss] && lv[LvL1]) bump_count(CntStL1Miss);
         if (lv[LvNa]) bump_count(CntStNa);
      end else begin
         bump_count(CntNoParse);
         return StatusNoParse;
      end

      if (r.map_flags != 2'b11) begin
         bump_count(CntNoMap);
         return StatusNoMap;
      end
      return StatusOk;
   endfunction

   function automatic msc_rsp_type predict_response(input msc_req_type r);
      msc_rsp_type p;
      p = '0;
      if (r.kind == KindRead) begin
         p.status        = StatusOk;
         p.counter_value = 32'(class_count[r.counter_select]);
      end else begin
         p.status = classify_sample(r);
      end
      return p;
   endfunction

   always @(posedge clock) begin
      msc_rsp_type want;
      if (reset) begin
         expected_rsp_q.delete();
         for (int i = 0; i < NumCounters; i++) class_count[i] = '0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response with none pending: status %0d value %0d",
                        $time, rsp_data.status, rsp_data.counter_value);
               fail_count = fail_count + 1;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.counter_value !== want.counter_value) begin
                  $display("%0t: counter_value mismatch: expected %0d actual %0d",
                           $time, want.counter_value, rsp_data.counter_value);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(predict_response(req_data));
         end
         pending_count <= expected_rsp_q.size();
      end
   end

endmodule

>>> verif/mem_sample_class_counters_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mem_sample_class_counters_tb
// Stimulus and verdict for the sample class counter block.
// ----------------------------------------------------------------------------
// A directed set covers field extremes, every operation and the corner cases
// of classification, then random requests run in four phases of sender
// idling and receiver stalling. Each phase ends with a read of all counters
// and a drain. Checking is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module mem_sample_class_counters_tb;
   import msc_pkg::*;

   localparam int IdleLimit    = 5000;
   localparam int RandomPerPhase = 200;

   localparam logic [4:0] OpNa       = 5'b00001;
   localparam logic [4:0] OpLoad     = 5'b00010;
   localparam logic [4:0] OpStore    = 5'b00100;
   localparam logic [4:0] OpPrefetch = 5'b01000;
   localparam logic [4:0] OpExec     = 5'b10000;

   localparam logic [13:0] LvlNa     = 14'h0001;
   localparam logic [13:0] LvlHit    = 14'h0002;
   localparam logic [13:0] LvlMiss   = 14'h0004;
   localparam logic [13:0] LvlL1     = 14'h0008;
   localparam logic [13:0] LvlLfb    = 14'h0010;
   localparam logic [13:0] LvlL2     = 14'h0020;
   localparam logic [13:0] LvlL3     = 14'h0040;
   localparam logic [13:0] LvlLocRam = 14'h0080;
   localparam logic [13:0] LvlRemRam1 = 14'h0100;
   localparam logic [13:0] LvlRemRam2 = 14'h0200;
   localparam logic [13:0] LvlRemCce1 = 14'h0400;
   localparam logic [13:0] LvlRemCce2 = 14'h0800;
   localparam logic [13:0] LvlIo     = 14'h1000;
   localparam logic [13:0] LvlUnc    = 14'h2000;

   localparam logic [4:0] SnpNone = 5'b00010;
   localparam logic [4:0] SnpHit  = 5'b00100;
   localparam logic [4:0] SnpMiss = 5'b01000;
   localparam logic [4:0] SnpHitm = 5'b10000;

   localparam logic [1:0] SnpxFwd  = 2'b01;
   localparam logic [1:0] SnpxPeer = 2'b10;

   localparam logic [1:0] MapNone  = 2'b00;
   localparam logic [1:0] MapData  = 2'b01;
   localparam logic [1:0] MapInstr = 2'b10;
   localparam logic [1:0] MapBoth  = 2'b11;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   msc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   msc_rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int quiet_cycles   = 0;

   int phase_idle [4]  = '{0, 49, 0, 37};
   int phase_stall [4] = '{0, 0, 49, 37};

   always #1 clock = ~clock;

   mem_sample_class_counters u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   msc_class_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic msc_req_type sample_req(input logic [4:0] op, input logic [13:0] lvl,
                                              input logic [4:0] snp, input logic [1:0] snpx,
                                              input logic remote, input logic [2:0] hops,
                                              input logic addr, input logic [1:0] map);
      msc_req_type r;
      r                  = '0;
      r.kind             = KindSample;
      r.op_flags         = op;
      r.level_flags      = lvl;
      r.snoop_flags      = snp;
      r.snoopx_flags     = snpx;
      r.remote_flag      = remote;
      r.hop_count        = hops;
      r.has_data_address = addr;
      r.map_flags        = map;
      return r;
   endfunction

   function automatic msc_req_type read_req(input int idx);
      msc_req_type r;
      r                = '0;
      r.kind           = KindRead;
      r.counter_select = idx[4:0];
      return r;
   endfunction

   // mostly loads and stores with an address and both mappings, so that the
   // level and snoop decode is reached; the rest is raw noise
   function automatic msc_req_type random_request(input int read_pct);
      msc_req_type r;
      int          pick;
      r    = msc_req_type'({$urandom, $urandom});
      pick = $urandom_range(99);
      r.kind = (pick < read_pct) ? KindRead : KindSample;
      pick = $urandom_range(99);
      if (pick < 45) begin
         r.op_flags[1] = 1'b1;
      end else if (pick < 75) begin
         r.op_flags[2:1] = 2'b10;
      end
      if ($urandom_range(99) < 70) r.level_flags[1] = 1'b1;
      if ($urandom_range(99) < 50) r.hop_count = 3'd0;
      r.has_data_address = ($urandom_range(99) < 90);
      if ($urandom_range(99) < 80) r.map_flags = MapBoth;
      return r;
   endfunction

   task automatic send_req(input msc_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      msc_req_type r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_req(read_req(CntNrEntries));
      send_req(read_req(CntNoParse));
      send_req(sample_req('0, '0, '0, '0, 1'b0, 3'd0, 1'b0, MapNone));
      r      = '1;
      r.kind = KindSample;
      send_req(r);
      send_req(sample_req(OpLoad, LvlHit | LvlL1, SnpNone, '0, 1'b0, 3'd0, 1'b0, MapBoth));
      send_req(sample_req(OpStore, LvlHit | LvlL1, SnpNone, '0, 1'b0, 3'd0, 1'b0, MapBoth));
      send_req(sample_req(OpLoad, LvlHit | LvlL2 | LvlL3, SnpHitm, SnpxPeer, 1'b0, 3'd0,
                          1'b1, MapBoth));
      send_req(sample_req(OpLoad, LvlHit | LvlL2 | LvlL3, SnpMiss, SnpxFwd, 1'b0, 3'd0,
                          1'b1, MapBoth));
      send_req(sample_req(OpLoad, LvlHit, SnpHit, '0, 1'b1, 3'd0, 1'b1, MapBoth));
      send_req(sample_req(OpLoad, LvlHit, SnpNone, SnpxPeer, 1'b1, 3'd0, 1'b1, MapBoth));
      send_req(sample_req(OpLoad, LvlHit | LvlRemCce1, SnpHitm, '0, 1'b1, 3'd3,
                          1'b1, MapBoth));
      send_req(sample_req(OpLoad, LvlHit | LvlMiss | LvlLocRam | LvlRemRam2, SnpHit, '0,
                          1'b0, 3'd7, 1'b1, MapBoth));
      send_req(sample_req(OpLoad, LvlIo | LvlUnc | LvlLfb | LvlRemCce2 | LvlRemRam1,
                          SnpNone, SnpxPeer, 1'b0, 3'd0, 1'b1, MapBoth));
      send_req(sample_req(OpStore, LvlHit | LvlL1 | LvlUnc, SnpNone, '0, 1'b0, 3'd0,
                          1'b1, MapBoth));
      send_req(sample_req(OpStore, LvlMiss | LvlL1 | LvlNa, SnpNone, '0, 1'b0, 3'd0,
                          1'b1, MapBoth));
      send_req(sample_req(OpLoad | OpStore, LvlHit | LvlL1, SnpNone, '0, 1'b0, 3'd0,
                          1'b1, MapData));
      send_req(sample_req(OpStore, LvlHit, SnpNone, '0, 1'b0, 3'd0, 1'b1, MapInstr));
      send_req(sample_req(OpStore, LvlHit, SnpNone, '0, 1'b0, 3'd0, 1'b1, MapNone));
      send_req(sample_req(OpPrefetch, LvlHit, SnpNone, '0, 1'b0, 3'd0, 1'b1, MapBoth));
      send_req(sample_req(OpExec | OpNa, LvlHit, SnpNone, '0, 1'b0, 3'd0, 1'b1, MapBoth));
      r             = sample_req(OpLoad, LvlHit | LvlL1, SnpNone, '0, 1'b0, 3'd0, 1'b1, MapBoth);
      r.lock_flags  = 2'b11;
      r.block_flags = 3'b111;
      send_req(r);
      r      = '1;
      r.kind = KindRead;
      send_req(r);
      send_req(read_req(CntTotHitm));
      send_req(read_req(CntRmtPeer));
      send_req(read_req(CntLdShared));
      drain_responses();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = phase_idle[ph];
         rsp_stall_pct = phase_stall[ph];
         for (int i = 0; i < RandomPerPhase; i++) begin
            send_req(random_request(20));
         end
         for (int c = 0; c < NumCounters; c++) begin
            r                = random_request(0);
            r.kind           = KindRead;
            r.counter_select = c[4:0];
            send_req(r);
         end
         drain_responses();
      end

      rsp_stall_pct = 0;
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
